FILE: src/windowed_max_dp_tree_macros.svh
// Assertion helpers for the windowed max score tree.
`ifndef WINDOWED_MAX_DP_TREE_MACROS_SVH
`define WINDOWED_MAX_DP_TREE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define WMDT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define WMDT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/wmdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wmdt_pkg;

    localparam int POSITIONS_DEF = 1024;
    localparam int POS_W         = 10;
    localparam int CFG_W         = 10;
    localparam int CFG_IDX_W     = 1;
    localparam int SCORE_W       = 32;
    localparam int BEST_W        = 31;
    localparam int EPOCH_W       = 8;

    typedef logic signed [SCORE_W-1:0] t_score;

    localparam t_score EMPTY_SCORE = -32'sd1000000000;
    localparam t_score SCORE_MAX   = 32'sh7FFF_FFFF;
    localparam t_score SCORE_MIN   = 32'sh8000_0000;

    typedef enum logic [0:0] {
        KIND_BEGIN = 1'b0,
        KIND_BOOK  = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW = 1'b0,
        REG_START  = 1'b1
    } t_reg_idx;

    function automatic t_score score_max(input t_score a, input t_score b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

FILE: src/wmdt_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wmdt_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [wmdt_pkg::POS_W-1:0]    position;
    logic signed [wmdt_pkg::SCORE_W-1:0] gain;

    modport source (output valid, output kind, output position, output gain, input ready);
    modport sink   (input valid, input kind, input position, input gain, output ready);
endinterface

`default_nettype wire

FILE: src/wmdt_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wmdt_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [wmdt_pkg::SCORE_W-1:0] dp_value;
    logic [wmdt_pkg::BEST_W-1:0]         best;

    modport source (output valid, output dp_value, output best, input ready);
    modport sink   (input valid, input dp_value, input best, output ready);
endinterface

`default_nettype wire

FILE: src/windowed_max_dp_tree.sv
`timescale 1ns / 1ps
`default_nettype none
// Windowed max score tree: range-max, point-update tree over POSITIONS slots.
// Input channel i_item (valid/ready): kind, position, gain. A begin item empties
// every slot and seeds start_position with 0; a book item takes the max over the
// slots position +/- window, adds gain with 32-bit saturation, stores it in its
// slot and reports it. Output channel o_res (valid/ready): dp_value, best.
// Configuration: i_cfg_we/i_cfg_index/i_cfg_data, index 0 window, 1 start_position;
// write only while no item is in flight.
// One item at a time. All tree nodes sit in one 2*POSITIONS-entry memory with a
// registered read; every query read and every update step goes through its
// single read port. A book item queries its window, adds gain, writes its leaf,
// updates the path up to the root, then queries all leaves for best; a begin
// item writes its seed leaf if start_position is in range, updates the path and
// queries for best. The next item can be taken in the cycle the result appears.
// Entries carry an 8-bit epoch tag, so a begin item empties the tree by bumping
// the epoch; every 256th begin item instead sweeps all 2*POSITIONS entries.
// Reset: control registers clear, then the same sweep runs with i_item
// not ready. Results sit in an output register; a new item is accepted while a
// result waits, and the block stalls only when its next result has nowhere to go.
module windowed_max_dp_tree #(
    parameter int POSITIONS = wmdt_pkg::POSITIONS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [wmdt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [wmdt_pkg::CFG_W-1:0]       i_cfg_data,
    wmdt_in_if.sink                               i_item,
    wmdt_out_if.source                            o_res
);

`include "windowed_max_dp_tree_macros.svh"

    localparam int DEPTH  = 2 * POSITIONS;
    localparam int AW     = $clog2(DEPTH);
    localparam int NW     = AW + 1;
    localparam int SLOT_W = $clog2(POSITIONS);
    localparam int CW     = ((SLOT_W > wmdt_pkg::POS_W) ? SLOT_W : wmdt_pkg::POS_W) + 2;
    localparam int XW     = (CW > NW) ? CW : NW;
    localparam int EW     = wmdt_pkg::EPOCH_W;
    localparam int SW     = wmdt_pkg::SCORE_W;
    localparam int MW     = EW + SW;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_QUERY = 10'b00_0000_0100,
        S_QWAIT = 10'b00_0000_1000,
        S_SUM   = 10'b00_0001_0000,
        S_LEAF  = 10'b00_0010_0000,
        S_UPRD  = 10'b00_0100_0000,
        S_UPWB  = 10'b00_1000_0000,
        S_BEST  = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } t_state;

    logic [MW-1:0] mem [DEPTH];

    t_state                      r_state, n_state;
    logic [wmdt_pkg::CFG_W-1:0]  r_window;
    logic [wmdt_pkg::CFG_W-1:0]  r_start;
    logic [EW-1:0]               r_epoch, n_epoch;
    logic [AW-1:0]               r_clr, n_clr;
    logic                        r_seed, n_seed;
    logic                        r_acc, n_acc;
    logic                        r_out_valid, n_out_valid;

    logic [NW-1:0]               r_l, n_l;
    logic [NW-1:0]               r_r, n_r;
    wmdt_pkg::t_score            r_m, n_m;
    logic                        r_phase, n_phase;
    wmdt_pkg::t_score            r_gain, n_gain;
    wmdt_pkg::t_score            r_dp, n_dp;
    wmdt_pkg::t_score            r_cur, n_cur;
    logic [AW-1:0]               r_node, n_node;
    logic                        r_store, n_store;
    wmdt_pkg::t_score            r_out_dp, n_out_dp;
    logic [wmdt_pkg::BEST_W-1:0] r_out_best, n_out_best;
    logic [MW-1:0]               r_rd_data;

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [MW-1:0]               mem_wdata;
    logic [AW-1:0]               mem_raddr;

    wmdt_pkg::t_score            rd_score;
    wmdt_pkg::t_score            upd_score;
    wmdt_pkg::t_score            sat_sum;
    logic signed [SW:0]          sum_x;

    logic [XW-1:0] pos_x, win_x, start_x, n_x;
    logic [XW-1:0] lo_x, hi_raw, hi_x;
    logic          win_empty, pos_in, start_in;
    logic [NW-1:0] win_l, win_r;
    logic [AW-1:0] pos_leaf, start_leaf;

    assign i_item.ready   = (r_state == S_IDLE);
    assign o_res.valid    = r_out_valid;
    assign o_res.dp_value = r_out_dp;
    assign o_res.best     = r_out_best;

    assign rd_score  = (r_rd_data[MW-1 -: EW] == r_epoch) ?
                       wmdt_pkg::t_score'(r_rd_data[SW-1:0]) : wmdt_pkg::EMPTY_SCORE;
    assign upd_score = wmdt_pkg::score_max(r_cur, rd_score);

    assign sum_x   = $signed({r_m[SW-1], r_m}) + $signed({r_gain[SW-1], r_gain});
    assign sat_sum = (sum_x[SW] != sum_x[SW-1]) ?
                     (sum_x[SW] ? wmdt_pkg::SCORE_MIN : wmdt_pkg::SCORE_MAX) :
                     wmdt_pkg::t_score'(sum_x[SW-1:0]);

    assign pos_x      = XW'(i_item.position);
    assign win_x      = XW'(r_window);
    assign start_x    = XW'(r_start);
    assign n_x        = XW'(POSITIONS);
    assign lo_x       = (pos_x >= win_x) ? (pos_x - win_x) : '0;
    assign hi_raw     = pos_x + win_x;
    assign hi_x       = (hi_raw > (n_x - XW'(1))) ? (n_x - XW'(1)) : hi_raw;
    assign win_empty  = (lo_x > hi_x);
    assign win_l      = win_empty ? '0 : NW'(lo_x + n_x);
    assign win_r      = win_empty ? '0 : NW'(hi_x + n_x + XW'(1));
    assign pos_in     = (pos_x < n_x);
    assign start_in   = (start_x < n_x);
    assign pos_leaf   = AW'(pos_x + n_x);
    assign start_leaf = AW'(start_x + n_x);

    always_comb begin
        n_state     = r_state;
        n_epoch     = r_epoch;
        n_clr       = r_clr;
        n_seed      = r_seed;
        n_acc       = 1'b0;
        n_out_valid = r_out_valid && !o_res.ready;
        n_l         = r_l;
        n_r         = r_r;
        n_m         = r_acc ? wmdt_pkg::score_max(r_m, rd_score) : r_m;
        n_phase     = r_phase;
        n_gain      = r_gain;
        n_dp        = r_dp;
        n_cur       = r_cur;
        n_node      = r_node;
        n_store     = r_store;
        n_out_dp    = r_out_dp;
        n_out_best  = r_out_best;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_raddr   = '0;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = {{EW{1'b0}}, wmdt_pkg::EMPTY_SCORE};
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_clr  = '0;
                    n_seed = 1'b0;
                    if (r_seed) begin
                        n_state = r_store ? S_LEAF : S_BEST;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (i_item.valid) begin
                    if (i_item.kind == wmdt_pkg::KIND_BEGIN) begin
                        n_dp    = '0;
                        n_cur   = '0;
                        n_store = start_in;
                        n_node  = start_leaf;
                        if (r_epoch == {EW{1'b1}}) begin
                            n_epoch = '0;
                            n_seed  = 1'b1;
                            n_clr   = '0;
                            n_state = S_CLEAR;
                        end else begin
                            n_epoch = r_epoch + EW'(1);
                            n_state = start_in ? S_LEAF : S_BEST;
                        end
                    end else begin
                        n_l     = win_l;
                        n_r     = win_r;
                        n_m     = wmdt_pkg::EMPTY_SCORE;
                        n_phase = 1'b0;
                        n_gain  = i_item.gain;
                        n_store = pos_in;
                        n_node  = pos_leaf;
                        n_state = S_QUERY;
                    end
                end
            end
            S_QUERY: begin
                if (r_l < r_r) begin
                    if (r_l[0]) begin
                        mem_raddr = AW'(r_l);
                        n_acc     = 1'b1;
                        n_l       = r_l + NW'(1);
                    end else if (r_r[0]) begin
                        mem_raddr = AW'(r_r - NW'(1));
                        n_acc     = 1'b1;
                        n_r       = r_r - NW'(1);
                    end else begin
                        n_l = r_l >> 1;
                        n_r = r_r >> 1;
                    end
                end else begin
                    n_state = S_QWAIT;
                end
            end
            S_QWAIT: begin
                n_state = r_phase ? S_DONE : S_SUM;
            end
            S_SUM: begin
                n_dp    = sat_sum;
                n_cur   = sat_sum;
                n_state = r_store ? S_LEAF : S_BEST;
            end
            S_LEAF: begin
                mem_we    = 1'b1;
                mem_waddr = r_node;
                mem_wdata = {r_epoch, r_cur};
                n_state   = S_UPRD;
            end
            S_UPRD: begin
                if (r_node == AW'(1)) begin
                    n_state = S_BEST;
                end else begin
                    mem_raddr = r_node ^ AW'(1);
                    n_state   = S_UPWB;
                end
            end
            S_UPWB: begin
                mem_we    = 1'b1;
                mem_waddr = r_node >> 1;
                mem_wdata = {r_epoch, upd_score};
                n_cur     = upd_score;
                n_node    = r_node >> 1;
                n_state   = S_UPRD;
            end
            S_BEST: begin
                n_l     = NW'(POSITIONS);
                n_r     = NW'(DEPTH);
                n_m     = wmdt_pkg::EMPTY_SCORE;
                n_phase = 1'b1;
                n_state = S_QUERY;
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_dp    = r_dp;
                    n_out_best  = (r_m > 32'sd0) ? r_m[wmdt_pkg::BEST_W-1:0] : '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_window    <= '0;
            r_start     <= '0;
            r_epoch     <= '0;
            r_clr       <= '0;
            r_seed      <= 1'b0;
            r_acc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_epoch     <= n_epoch;
            r_clr       <= n_clr;
            r_seed      <= n_seed;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    wmdt_pkg::REG_WINDOW: r_window <= i_cfg_data;
                    wmdt_pkg::REG_START:  r_start  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_l        <= n_l;
        r_r        <= n_r;
        r_m        <= n_m;
        r_phase    <= n_phase;
        r_gain     <= n_gain;
        r_dp       <= n_dp;
        r_cur      <= n_cur;
        r_node     <= n_node;
        r_store    <= n_store;
        r_out_dp   <= n_out_dp;
        r_out_best <= n_out_best;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[mem_raddr];
    end

    `WMDT_ASSERT_IMP(a_query_no_write, i_clk, i_rst_n, (r_state == S_QUERY), !mem_we, "tree written during a query")
    `WMDT_ASSERT_IMP(a_query_bound, i_clk, i_rst_n, (r_state == S_QUERY), (r_r <= NW'(DEPTH)), "query bound past the tree")
    `WMDT_ASSERT_IMP(a_update_node, i_clk, i_rst_n, (r_state == S_UPRD), (r_node != '0), "update walked past the root")
    `WMDT_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, (i_item.valid && i_item.ready), (r_state != S_IDLE), "accepted item left block idle")
    `WMDT_ASSERT_IMP(a_acc_from_query, i_clk, i_rst_n, r_acc, $past(r_state == S_QUERY), "read folded outside a query")

endmodule

`default_nettype wire

FILE: tb/sv/tb_windowed_max_dp_tree.sv
`timescale 1ns / 1ps

module tb_windowed_max_dp_tree;
    import wmdt_pkg::*;

    localparam int POSITIONS   = POSITIONS_DEF;
    localparam int DRAIN_WAIT  = 120;
    localparam int HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        t_kind             kind;
        logic [POS_W-1:0]  position;
        t_score            gain;
    } t_book_item;

    typedef struct {
        t_score            dp_value;
        logic [BEST_W-1:0] best;
    } t_score_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    wmdt_in_if  item_if ();
    wmdt_out_if res_if ();

    windowed_max_dp_tree dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_item      (item_if),
        .o_res       (res_if)
    );

    t_book_item    pending_items [$];
    t_score_result expected_scores [$];
    t_score        slot_score [POSITIONS];
    int            cur_window = 0;
    int            cur_start = 0;

    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    logic hold_go = 1'b0;

    int error_count = 0;
    int items_accepted = 0;
    int begins_accepted = 0;
    int results_checked = 0;
    int settings_used = 1;
    int cycle_count = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input t_score got, input t_score want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic t_score window_peak(input int center);
        int lo;
        int hi;
        t_score peak;
        peak = EMPTY_SCORE;
        lo = center - cur_window;
        hi = center + cur_window;
        if (lo < 0) lo = 0;
        if (hi > POSITIONS - 1) hi = POSITIONS - 1;
        for (int s = lo; s <= hi; s++)
            if (slot_score[s] > peak) peak = slot_score[s];
        return peak;
    endfunction

    function automatic void score_item(input logic kind, input logic [POS_W-1:0] pos,
                                       input t_score gain);
        t_score_result r;
        t_score peak;
        logic signed [SCORE_W+1:0] total;
        if (kind == KIND_BEGIN) begin
            foreach (slot_score[s]) slot_score[s] = EMPTY_SCORE;
            if (cur_start < POSITIONS) slot_score[cur_start] = '0;
            r.dp_value = '0;
        end else begin
            total = window_peak(int'(pos));
            total = total + gain;
            if (total > 34'sd2147483647) r.dp_value = SCORE_MAX;
            else if (total < -34'sd2147483648) r.dp_value = SCORE_MIN;
            else r.dp_value = t_score'(total);
            if (int'(pos) < POSITIONS) slot_score[pos] = r.dp_value;
        end
        peak = window_peak(POSITIONS / 2);
        foreach (slot_score[s])
            if (slot_score[s] > peak) peak = slot_score[s];
        r.best = (peak > 0) ? peak[BEST_W-1:0] : '0;
        expected_scores.push_back(r);
    endfunction

    always @(posedge i_clk) begin
        t_book_item nxt;
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
            item_if.kind <= KIND_BEGIN;
            item_if.position <= '0;
            item_if.gain <= '0;
            gap_left <= 0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                score_item(item_if.kind, item_if.position, item_if.gain);
                items_accepted++;
                if (item_if.kind == KIND_BEGIN) begins_accepted++;
            end
            if (!item_if.valid || item_if.ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    item_if.valid <= 1'b0;
                end else if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
                    gap_left <= $urandom_range(13, 0);
                    item_if.valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    nxt = pending_items.pop_front();
                    item_if.kind <= nxt.kind;
                    item_if.position <= nxt.position;
                    item_if.gain <= nxt.gain;
                    item_if.valid <= 1'b1;
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) hold_left <= 0;
        else if (hold_go) hold_left <= HOLD_CYCLES;
        else if (hold_left != 0) hold_left <= hold_left - 1;
    end

    always @(posedge i_clk) begin
        t_score_result want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                results_checked++;
                if (expected_scores.size() == 0) begin
                    report_mismatch("result with nothing pending, dp_value", res_if.dp_value, '0);
                end else begin
                    want = expected_scores.pop_front();
                    if (res_if.dp_value !== want.dp_value)
                        report_mismatch("dp_value", res_if.dp_value, want.dp_value);
                    if (res_if.best !== want.best)
                        report_mismatch("best", t_score'({1'b0, res_if.best}),
                                        t_score'({1'b0, want.best}));
                end
            end
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                res_if.ready <= 1'b0;
            end else if (sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct) begin
                stall_left <= $urandom_range(13, 0);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= (hold_left == 0);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d results still pending",
                     cycle_count, expected_scores.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic push_item(input t_kind kind, input int pos, input t_score gain);
        t_book_item it;
        it.kind = kind;
        it.position = POS_W'(pos);
        it.gain = gain;
        pending_items.push_back(it);
    endtask

    task automatic write_reg(input t_reg_idx idx, input int val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(val);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == REG_WINDOW) cur_window = val;
        else cur_start = val;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || item_if.valid || expected_scores.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic t_score random_gain();
        case ($urandom_range(9))
            0: return SCORE_MAX;
            1: return SCORE_MIN;
            2, 3: return t_score'($urandom);
            default: return t_score'(int'($urandom_range(2000)) - 1000);
        endcase
    endfunction

    task automatic run_random_phase(input int window, input int start, input int idle_pct,
                                    input bit with_hold, input int count);
        int last_pos;
        int pos;
        int pick;
        write_reg(REG_WINDOW, window);
        write_reg(REG_START, start);
        settings_used++;
        src_idle_pct = idle_pct;
        sink_idle_pct = idle_pct;
        last_pos = cur_start;
        push_item(KIND_BEGIN, int'($urandom_range(POSITIONS - 1)), t_score'($urandom));
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                push_item(KIND_BEGIN, int'($urandom_range(POSITIONS - 1)), random_gain());
                last_pos = cur_start;
            end else begin
                if (pick < 60)
                    pos = last_pos + int'($urandom_range(2 * cur_window + 2)) - cur_window - 1;
                else if (pick < 88)
                    pos = int'($urandom_range(POSITIONS - 1));
                else
                    pos = pick[0] ? 0 : POSITIONS - 1;
                if (pos < 0) pos = 0;
                if (pos > POSITIONS - 1) pos = POSITIONS - 1;
                push_item(KIND_BOOK, pos, random_gain());
                last_pos = pos;
            end
        end
        if (with_hold) begin
            @(posedge i_clk);
            hold_go <= 1'b1;
            @(posedge i_clk);
            hold_go <= 1'b0;
        end
        wait_drained();
    endtask

    initial begin
        foreach (slot_score[s]) slot_score[s] = EMPTY_SCORE;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk);
        while (!item_if.ready);

        // reset settings: window 0, start 0, tree empty
        src_idle_pct = 20;
        sink_idle_pct = 20;
        push_item(KIND_BOOK, 5, -32'sd5);
        push_item(KIND_BOOK, 5, SCORE_MIN);
        push_item(KIND_BOOK, 1023, SCORE_MAX);
        push_item(KIND_BOOK, 1023, SCORE_MAX);
        push_item(KIND_BEGIN, 1023, -32'sd1);
        push_item(KIND_BOOK, 0, SCORE_MAX);
        push_item(KIND_BOOK, 0, '0);
        push_item(KIND_BOOK, 0, SCORE_MIN);
        push_item(KIND_BOOK, 1, 32'sd100);
        push_item(KIND_BEGIN, 0, '0);
        wait_drained();

        write_reg(REG_WINDOW, 1023);
        write_reg(REG_START, 1023);
        settings_used++;
        push_item(KIND_BEGIN, 512, SCORE_MAX);
        push_item(KIND_BOOK, 0, -32'sd3);
        push_item(KIND_BOOK, 1023, 32'sd5);
        push_item(KIND_BOOK, 600, 32'sd12345);
        push_item(KIND_BOOK, 0, SCORE_MIN);
        push_item(KIND_BOOK, 1023, -32'sd1);
        push_item(KIND_BOOK, 341, 32'sh5555_5555);
        push_item(KIND_BOOK, 682, 32'shAAAA_AAAA);
        push_item(KIND_BEGIN, 1023, SCORE_MIN);
        push_item(KIND_BOOK, 300, '0);
        wait_drained();

        run_random_phase(4, 512, 30, 1'b0, 80);
        run_random_phase(0, 1023, 10, 1'b1, 80);
        run_random_phase(1023, 0, 50, 1'b0, 80);
        run_random_phase(37, int'($urandom_range(POSITIONS - 1)), 25, 1'b0, 80);
        run_random_phase(1, 3, 0, 1'b0, 80);

        while (expected_scores.size() != 0) begin
            report_mismatch("result never arrived, dp_value", '0,
                            expected_scores.pop_front().dp_value);
        end
        $display("Run covered %0d items (%0d begin items) under %0d register settings,",
                 items_accepted, begins_accepted, settings_used);
        $display("with %0d results checked, random stalls and one long output hold-off.",
                 results_checked);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
